// File: src/dwg_pkg.sv
// dwg_pkg: shared types and constants of the depth window to gray core
// register indexes, mapping modes, pipeline beat structs
// depends on nothing
`default_nettype none

package dwg_pkg;

  localparam int unsigned DEPTH_W        = 16;
  localparam int unsigned LEVEL_W        = 8;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = LEVEL_W / BITS_PER_STAGE;
  localparam int unsigned NUM_W          = DEPTH_W + LEVEL_W;

  // register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_NEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

  // mapping modes
  localparam logic [MODE_W-1:0] MODE_BINARY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLAMPED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WINDOW  = 2'd2;

  localparam logic [DEPTH_W-1:0] NEAR_RESET = '0;
  localparam logic [DEPTH_W-1:0] FAR_RESET  = '1;
  localparam logic [MODE_W-1:0]  MODE_RESET = MODE_BINARY;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_FULL,
    SEL_RAMP
  } level_sel_e;

  typedef struct packed {
    logic [DEPTH_W-1:0] near_bound;
    logic [DEPTH_W-1:0] far_bound;
    logic [MODE_W-1:0]  pixel_mode;
    logic [DEPTH_W-1:0] span;
  } cfg_t;

  // one pixel travelling through the divider
  typedef struct packed {
    logic               valid;
    logic               eof;
    level_sel_e         sel;
    logic [DEPTH_W-1:0] rem;
    logic [LEVEL_W-1:0] num_lo;
    logic [LEVEL_W-1:0] quo;
  } div_beat_t;

endpackage

`default_nettype wire

// File: src/dwg_cfg_regs.sv
// dwg_cfg_regs: near, far and mode registers plus registered ramp span
// depends on dwg_pkg
`default_nettype none

module dwg_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dwg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dwg_pkg::DEPTH_W-1:0]   cfg_wdata_i,
  output dwg_pkg::cfg_t                      cfg_o
);

  logic [dwg_pkg::DEPTH_W-1:0] near_q, near_d;
  logic [dwg_pkg::DEPTH_W-1:0] far_q, far_d;
  logic [dwg_pkg::MODE_W-1:0]  mode_q, mode_d;
  logic [dwg_pkg::DEPTH_W-1:0] span_q, span_d;

  always_comb begin
    near_d = near_q;
    far_d  = far_q;
    mode_d = mode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        dwg_pkg::REG_NEAR: near_d = cfg_wdata_i;
        dwg_pkg::REG_FAR:  far_d  = cfg_wdata_i;
        dwg_pkg::REG_MODE: mode_d = cfg_wdata_i[dwg_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
    // span is registered from the bound registers and settles in the cycle after they take a write
    span_d = far_q - near_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= dwg_pkg::NEAR_RESET;
      far_q  <= dwg_pkg::FAR_RESET;
      mode_q <= dwg_pkg::MODE_RESET;
      span_q <= dwg_pkg::FAR_RESET - dwg_pkg::NEAR_RESET;
    end else begin
      near_q <= near_d;
      far_q  <= far_d;
      mode_q <= mode_d;
      span_q <= span_d;
    end
  end

  assign cfg_o.near_bound = near_q;
  assign cfg_o.far_bound  = far_q;
  assign cfg_o.pixel_mode = mode_q;
  assign cfg_o.span       = span_q;

endmodule

`default_nettype wire

// File: src/dwg_prep.sv
// dwg_prep: first pipeline stage, classifies the pixel and forms 255*(d-near)
// depends on dwg_pkg
`default_nettype none

module dwg_prep (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [dwg_pkg::DEPTH_W-1:0] depth_i,
  input  wire logic                        eof_i,
  input  wire dwg_pkg::cfg_t               cfg_i,
  output dwg_pkg::div_beat_t               beat_o
);

  logic                        ge_near, le_far, in_window, ramp_ok;
  logic [dwg_pkg::DEPTH_W-1:0] diff;
  logic [dwg_pkg::NUM_W-1:0]   num;
  dwg_pkg::level_sel_e         sel;
  logic                        valid_q;
  dwg_pkg::div_beat_t          beat_q, beat_d;

  always_comb begin
    ge_near   = depth_i >= cfg_i.near_bound;
    le_far    = depth_i <= cfg_i.far_bound;
    in_window = ge_near && le_far;
    ramp_ok   = cfg_i.far_bound > cfg_i.near_bound;
    case (cfg_i.pixel_mode)
      dwg_pkg::MODE_BINARY: sel = in_window ? dwg_pkg::SEL_FULL : dwg_pkg::SEL_ZERO;
      dwg_pkg::MODE_CLAMPED: begin
        if (!(depth_i > cfg_i.near_bound)) sel = dwg_pkg::SEL_ZERO;
        else if (!(depth_i < cfg_i.far_bound)) sel = dwg_pkg::SEL_FULL;
        else sel = dwg_pkg::SEL_RAMP;
      end
      // equal bounds give an empty ramp, level zero
      dwg_pkg::MODE_WINDOW: sel = (in_window && ramp_ok) ? dwg_pkg::SEL_RAMP
                                                         : dwg_pkg::SEL_ZERO;
      default: sel = dwg_pkg::SEL_ZERO;
    endcase
    diff = (sel == dwg_pkg::SEL_RAMP) ? depth_i - cfg_i.near_bound : '0;
    // 255*diff as a shift and subtract
    num  = {diff, {dwg_pkg::LEVEL_W{1'b0}}} - {{dwg_pkg::LEVEL_W{1'b0}}, diff};

    beat_d.valid  = in_valid_i;
    beat_d.eof    = eof_i;
    beat_d.sel    = sel;
    beat_d.rem    = num[dwg_pkg::NUM_W-1:dwg_pkg::LEVEL_W];
    beat_d.num_lo = num[dwg_pkg::LEVEL_W-1:0];
    beat_d.quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// File: src/dwg_div_stage.sv
// dwg_div_stage: one registered stage of the restoring divider, two quotient bits
// depends on dwg_pkg
`default_nettype none

module dwg_div_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [dwg_pkg::DEPTH_W-1:0] span_i,
  input  wire dwg_pkg::div_beat_t          beat_i,
  output dwg_pkg::div_beat_t               beat_o
);

  logic [dwg_pkg::DEPTH_W:0]   trial;
  logic [dwg_pkg::DEPTH_W-1:0] rem;
  logic [dwg_pkg::LEVEL_W-1:0] lo;
  logic [dwg_pkg::LEVEL_W-1:0] quo;
  logic                        valid_q;
  dwg_pkg::div_beat_t          beat_q, beat_d;

  // remainder stays below span, so the trial fits in one extra bit
  always_comb begin
    rem   = beat_i.rem;
    lo    = beat_i.num_lo;
    quo   = beat_i.quo;
    trial = '0;
    for (int i = 0; i < int'(dwg_pkg::BITS_PER_STAGE); i++) begin
      trial = {rem, lo[dwg_pkg::LEVEL_W-1]};
      lo    = {lo[dwg_pkg::LEVEL_W-2:0], 1'b0};
      if (trial >= {1'b0, span_i}) begin
        rem = dwg_pkg::DEPTH_W'(trial - {1'b0, span_i});
        quo = {quo[dwg_pkg::LEVEL_W-2:0], 1'b1};
      end else begin
        rem = trial[dwg_pkg::DEPTH_W-1:0];
        quo = {quo[dwg_pkg::LEVEL_W-2:0], 1'b0};
      end
    end
    beat_d        = beat_i;
    beat_d.rem    = rem;
    beat_d.num_lo = lo;
    beat_d.quo    = quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// File: src/depth_window_to_gray_core.sv
// depth_window_to_gray_core: top level, config registers, prep stage,
// four divider stages and the output register
// depends on dwg_pkg, dwg_cfg_regs, dwg_prep, dwg_div_stage
//
// Usage:
//   Input channel: a pixel beat (depth_i, end_of_frame_i) is taken at every
//   rising edge where start is high and busy is low. busy stays low, so one
//   pixel can be taken in every cycle, without gaps.
//   Result channel: done_o is high for one cycle with level_o and
//   frame_end_o; the result is taken at the edge that ends that cycle.
//   Path: a pixel taken at an edge passes the prep register, each divider
//   stage register and the output register before it shows on the result ports.
//   Throughput: one pixel per clock; the pipeline is prep stage, four
//   restoring divider stages of two quotient bits each, and the output register.
//   Config: cfg_we_i writes near, far or mode by cfg_idx_i; index three is
//   dropped. Write only while no pixel is in flight; the ramp span register
//   takes its new value in the cycle after the bound register does.
//   Reset: rst_ni clears all pipeline valid bits and loads near 0, far 65535,
//   mode binary window. The receiver cannot hold results off, so no
//   backpressure exists and nothing is ever stalled.
`default_nettype none

module depth_window_to_gray_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [dwg_pkg::DEPTH_W-1:0]   depth_i,
  input  wire logic                          end_of_frame_i,
  output      logic                          done_o,
  output      logic [dwg_pkg::LEVEL_W-1:0]   level_o,
  output      logic                          frame_end_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [dwg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dwg_pkg::DEPTH_W-1:0]   cfg_wdata_i
);

  dwg_pkg::cfg_t               cfg;
  dwg_pkg::div_beat_t          pipe [dwg_pkg::DIV_STAGES+1];
  dwg_pkg::div_beat_t          last;
  logic                        done_q;
  logic [dwg_pkg::LEVEL_W-1:0] level_q, level_d;
  logic                        frame_end_q;

  assign busy = 1'b0;

  dwg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dwg_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .depth_i    (depth_i),
    .eof_i      (end_of_frame_i),
    .cfg_i      (cfg),
    .beat_o     (pipe[0])
  );

  for (genvar g = 0; g < int'(dwg_pkg::DIV_STAGES); g++) begin : g_div
    dwg_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .span_i (cfg.span),
      .beat_i (pipe[g]),
      .beat_o (pipe[g+1])
    );
  end

  assign last = pipe[dwg_pkg::DIV_STAGES];

  always_comb begin
    case (last.sel)
      dwg_pkg::SEL_RAMP: level_d = last.quo;
      dwg_pkg::SEL_FULL: level_d = dwg_pkg::LEVEL_FULL;
      default:           level_d = dwg_pkg::LEVEL_ZERO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q     <= level_d;
    frame_end_q <= last.eof;
  end

  assign done_o      = done_q;
  assign level_o     = level_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// File: src/dwg_checker.sv
// dwg_checker: port-level checks of the depth window to gray core
// depends on dwg_pkg; bound to depth_window_to_gray_core below
`default_nettype none

module dwg_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          end_of_frame_i,
  input wire logic                          done_o,
  input wire logic [dwg_pkg::LEVEL_W-1:0]   level_o,
  input wire logic                          frame_end_o,
  input wire logic                          cfg_we_i,
  input wire logic [dwg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [dwg_pkg::DEPTH_W-1:0]   cfg_wdata_i
);

  // every result traces back to an accepted input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 6))
    else $error("result without a matching input beat");

  // every accepted beat gives a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 done_o)
    else $error("input beat lost in the pipeline");

  // frame marker stays aligned with its pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (frame_end_o == $past(end_of_frame_i, 6)))
    else $error("frame end flag out of step with its pixel");

  // binary window after a mode write of zero gives only extremes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(cfg_we_i && (cfg_idx_i == dwg_pkg::REG_MODE)
                     && (cfg_wdata_i[dwg_pkg::MODE_W-1:0] == dwg_pkg::MODE_BINARY), 7))
    |-> ((level_o == dwg_pkg::LEVEL_ZERO) || (level_o == dwg_pkg::LEVEL_FULL)))
    else $error("binary window produced an intermediate level");

endmodule

bind depth_window_to_gray_core dwg_checker u_dwg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .end_of_frame_i (end_of_frame_i),
  .done_o         (done_o),
  .level_o        (level_o),
  .frame_end_o    (frame_end_o),
  .cfg_we_i       (cfg_we_i),
  .cfg_idx_i      (cfg_idx_i),
  .cfg_wdata_i    (cfg_wdata_i)
);

`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for depth_window_to_gray_core
// directed and random pixel beats against a predictor of the gray mapping
// depends on dwg_pkg and the core rtl
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned PIPE_LATENCY = 6;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned RAND_PHASES  = 27;
  localparam int unsigned PHASE_PIXELS = 50;
  // index three has no register behind it, mode three is unused
  localparam logic [dwg_pkg::CFG_IDX_W-1:0] REG_NONE    = 2'd3;
  localparam logic [dwg_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;

  typedef struct {
    logic [dwg_pkg::DEPTH_W-1:0] depth;
    logic                        eof;
    int unsigned                 gap;
    bit                          drain;
  } pixel_t;

  typedef struct {
    logic [dwg_pkg::LEVEL_W-1:0] level;
    logic                        frame_end;
    logic [dwg_pkg::DEPTH_W-1:0] depth;
  } gray_exp_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                          pix_start = 1'b0;
  logic [dwg_pkg::DEPTH_W-1:0]   pix_depth = '0;
  logic                          pix_eof   = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [dwg_pkg::CFG_IDX_W-1:0] cfg_idx   = dwg_pkg::REG_NEAR;
  logic [dwg_pkg::DEPTH_W-1:0]   cfg_wdata = '0;

  logic                        busy;
  logic                        done_o;
  logic [dwg_pkg::LEVEL_W-1:0] level_o;
  logic                        frame_end_o;

  // copy of the register file as the core should hold it
  logic [dwg_pkg::DEPTH_W-1:0] near_q = dwg_pkg::NEAR_RESET;
  logic [dwg_pkg::DEPTH_W-1:0] far_q  = dwg_pkg::FAR_RESET;
  logic [dwg_pkg::MODE_W-1:0]  mode_q = dwg_pkg::MODE_RESET;

  pixel_t      pixels_pending[$];
  gray_exp_t   gray_due[$];
  pixel_t      queued_pix;
  gray_exp_t   due_entry;
  gray_exp_t   seen_entry;
  int unsigned gap_left     = 0;
  int unsigned idle_style   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  depth_window_to_gray_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .start          (pix_start),
    .busy           (busy),
    .depth_i        (pix_depth),
    .end_of_frame_i (pix_eof),
    .done_o         (done_o),
    .level_o        (level_o),
    .frame_end_o    (frame_end_o),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [dwg_pkg::LEVEL_W-1:0] gray_level(
      input logic [dwg_pkg::DEPTH_W-1:0] d);
    logic                        in_win;
    logic [31:0]                 dd;
    logic [31:0]                 nn;
    logic [31:0]                 ff;
    logic [31:0]                 ramp;
    logic [dwg_pkg::LEVEL_W-1:0] lvl;
    dd = {16'd0, d};
    nn = {16'd0, near_q};
    ff = {16'd0, far_q};
    in_win = (dd >= nn) && (dd <= ff);
    // zero-length or inverted span never ramps
    if (ff > nn) begin
      ramp = (32'd255 * (dd - nn)) / (ff - nn);
    end else begin
      ramp = 32'd0;
    end
    case (mode_q)
      dwg_pkg::MODE_BINARY: lvl = in_win ? dwg_pkg::LEVEL_FULL : dwg_pkg::LEVEL_ZERO;
      dwg_pkg::MODE_CLAMPED: begin
        if (dd <= nn) lvl = dwg_pkg::LEVEL_ZERO;
        else if (dd >= ff) lvl = dwg_pkg::LEVEL_FULL;
        else lvl = ramp[dwg_pkg::LEVEL_W-1:0];
      end
      dwg_pkg::MODE_WINDOW: lvl = in_win ? ramp[dwg_pkg::LEVEL_W-1:0] : dwg_pkg::LEVEL_ZERO;
      default: lvl = dwg_pkg::LEVEL_ZERO;
    endcase
    return lvl;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_cnt < MAX_PRINTS) begin
      $display("tb: mismatch at cycle %0d: %s", cycle_cnt, what);
    end
    mismatch_cnt++;
  endtask

  // driver: one pixel beat per handshake, gaps drawn per beat
  always @(posedge clk_i) begin
    if (!rst_n) begin
      pix_start <= 1'b0;
    end else begin
      if (pix_start && !busy) begin
        due_entry.level     = gray_level(pix_depth);
        due_entry.frame_end = pix_eof;
        due_entry.depth     = pix_depth;
        gray_due.push_back(due_entry);
      end
      if (pix_start && busy) begin
        // beat not taken yet, keep it on the ports
      end else if (gap_left != 0) begin
        gap_left--;
        pix_start <= 1'b0;
      end else if (pixels_pending.size() != 0 &&
                   !(pixels_pending[0].drain && gray_due.size() != 0)) begin
        queued_pix = pixels_pending.pop_front();
        pix_start <= 1'b1;
        pix_depth <= queued_pix.depth;
        pix_eof   <= queued_pix.eof;
        gap_left  = queued_pix.gap;
      end else begin
        pix_start <= 1'b0;
      end
    end
  end

  // monitor: every done beat against the oldest expected gray level
  always @(posedge clk_i) begin
    if (rst_n && done_o) begin
      if (gray_due.size() == 0) begin
        report_mismatch("result beat with no pixel outstanding");
      end else begin
        seen_entry = gray_due.pop_front();
        if (level_o !== seen_entry.level) begin
          report_mismatch($sformatf(
            "depth %0d mode %0d near %0d far %0d: level %0d, want %0d",
            seen_entry.depth, mode_q, near_q, far_q, level_o, seen_entry.level));
        end
        if (frame_end_o !== seen_entry.frame_end) begin
          report_mismatch($sformatf("depth %0d: frame_end %b, want %b", seen_entry.depth,
                                    frame_end_o, seen_entry.frame_end));
        end
      end
    end
  end

  task automatic wait_idle();
    while (pixels_pending.size() != 0 || pix_start || gray_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // all three registers back to back, optionally a write to the empty index
  task automatic configure(input logic [dwg_pkg::DEPTH_W-1:0] near_v,
                           input logic [dwg_pkg::DEPTH_W-1:0] far_v,
                           input logic [dwg_pkg::DEPTH_W-1:0] mode_word,
                           input bit poke_none);
    wait_idle();
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= dwg_pkg::REG_NEAR;
    cfg_wdata <= near_v;
    @(posedge clk_i);
    cfg_idx   <= dwg_pkg::REG_FAR;
    cfg_wdata <= far_v;
    @(posedge clk_i);
    cfg_idx   <= dwg_pkg::REG_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk_i);
    if (poke_none) begin
      cfg_idx   <= REG_NONE;
      cfg_wdata <= dwg_pkg::DEPTH_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    near_q = near_v;
    far_q  = far_v;
    mode_q = mode_word[dwg_pkg::MODE_W-1:0];
    // span register trails the bound writes
    repeat (3) @(posedge clk_i);
  endtask

  task automatic push_pixel(input logic [dwg_pkg::DEPTH_W-1:0] d, input logic eof,
                            input bit drain);
    pixel_t p;
    p.depth = d;
    p.eof   = eof;
    p.drain = drain;
    case (idle_style)
      0: p.gap = 0;
      1: p.gap = $urandom_range(17, 0);
      default: p.gap = ($urandom_range(7, 0) == 0) ? $urandom_range(17, 0) : 0;
    endcase
    pixels_pending.push_back(p);
  endtask

  function automatic logic [dwg_pkg::DEPTH_W-1:0] clip_depth(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return dwg_pkg::DEPTH_W'(v);
  endfunction

  function automatic logic [dwg_pkg::DEPTH_W-1:0] pick_depth();
    int lo;
    int hi;
    lo = (near_q < far_q) ? int'(near_q) : int'(far_q);
    hi = (near_q < far_q) ? int'(far_q) : int'(near_q);
    case ($urandom_range(7, 0))
      0, 7: return dwg_pkg::DEPTH_W'($urandom);
      1: return clip_depth(int'(near_q) + int'($urandom_range(4, 0)) - 2);
      2: return clip_depth(int'(far_q) + int'($urandom_range(4, 0)) - 2);
      6: return $urandom_range(1, 0) ? '1 : '0;
      default: return dwg_pkg::DEPTH_W'($urandom_range(hi, lo));
    endcase
  endfunction

  initial begin
    logic [dwg_pkg::DEPTH_W-1:0] a;
    logic [dwg_pkg::DEPTH_W-1:0] b;
    logic [dwg_pkg::DEPTH_W-1:0] near_v;
    logic [dwg_pkg::DEPTH_W-1:0] far_v;
    logic [dwg_pkg::MODE_W-1:0]  mode_v;

    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset settings: full window, binary
    idle_style = 1;
    push_pixel(16'd0, 1'b1, 1'b0);
    push_pixel(16'hFFFF, 1'b0, 1'b0);

    // clamped ramp, junk in the upper mode bits, stray write to the empty index
    configure(16'd1000, 16'd2000, {14'h3FFF, dwg_pkg::MODE_CLAMPED}, 1'b1);
    push_pixel(16'd999, 1'b0, 1'b0);
    push_pixel(16'd1000, 1'b0, 1'b0);
    push_pixel(16'd1001, 1'b0, 1'b0);
    push_pixel(16'd1500, 1'b1, 1'b0);
    push_pixel(16'd1999, 1'b0, 1'b0);
    push_pixel(16'd2000, 1'b0, 1'b0);
    push_pixel(16'd2001, 1'b0, 1'b0);

    idle_style = 0;
    configure(16'd1000, 16'd2000, {14'd0, dwg_pkg::MODE_WINDOW}, 1'b0);
    push_pixel(16'd999, 1'b0, 1'b0);
    push_pixel(16'd1000, 1'b0, 1'b0);
    push_pixel(16'd1999, 1'b0, 1'b0);
    push_pixel(16'd2000, 1'b1, 1'b0);
    push_pixel(16'd2001, 1'b0, 1'b0);

    // equal bounds
    configure(16'd5000, 16'd5000, {14'd0, dwg_pkg::MODE_WINDOW}, 1'b0);
    push_pixel(16'd4999, 1'b0, 1'b0);
    push_pixel(16'd5000, 1'b0, 1'b0);
    push_pixel(16'd5001, 1'b0, 1'b0);
    configure(16'd5000, 16'd5000, {14'd0, dwg_pkg::MODE_CLAMPED}, 1'b0);
    push_pixel(16'd5000, 1'b0, 1'b0);
    push_pixel(16'd5001, 1'b0, 1'b0);

    // near above far
    configure(16'd40000, 16'd100, {14'd0, dwg_pkg::MODE_BINARY}, 1'b0);
    push_pixel(16'd100, 1'b0, 1'b0);
    push_pixel(16'd40000, 1'b0, 1'b0);
    configure(16'd40000, 16'd100, {14'd0, dwg_pkg::MODE_CLAMPED}, 1'b0);
    push_pixel(16'd40000, 1'b0, 1'b0);
    push_pixel(16'd40001, 1'b0, 1'b0);

    // unused mode from an all-ones write
    configure(16'd0, 16'hFFFF, {14'h3FFF, MODE_UNUSED}, 1'b0);
    push_pixel(16'd1234, 1'b1, 1'b0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      a = dwg_pkg::DEPTH_W'($urandom);
      b = dwg_pkg::DEPTH_W'($urandom);
      case ($urandom_range(9, 0))
        0: begin near_v = '0; far_v = '1; end
        1: begin near_v = a; far_v = a; end
        2: begin near_v = (a > b) ? a : b; far_v = (a > b) ? b : a; end
        3: begin
          near_v = dwg_pkg::DEPTH_W'($urandom_range(65000, 0));
          far_v  = near_v + dwg_pkg::DEPTH_W'($urandom_range(8, 1));
        end
        4: begin near_v = '0; far_v = a; end
        5: begin near_v = a; far_v = '1; end
        default: begin near_v = (a < b) ? a : b; far_v = (a < b) ? b : a; end
      endcase
      mode_v = ($urandom_range(9, 0) == 0) ? MODE_UNUSED
                                           : dwg_pkg::MODE_W'($urandom_range(2, 0));
      configure(near_v, far_v, {14'($urandom), mode_v}, $urandom_range(3, 0) == 0);
      idle_style = p % 3;
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        push_pixel(pick_depth(), $urandom_range(15, 0) == 0, (p % 4 == 1) && (i == 25));
      end
    end

    wait_idle();
    repeat (PIPE_LATENCY + 6) @(posedge clk_i);
    if (mismatch_cnt == 0 && gray_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
